@@ rtl/mbd_pkg.sv @@
package mbd_pkg;

    // Error codes carried with each result
    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_YEAR  = 2'd1,
        ERR_MONTH = 2'd2
    } err_t;

    // Range limits
    localparam logic [13:0] YEAR_MAX  = 14'd9999;
    localparam logic [3:0]  MONTH_MAX = 4'd12;

    // Seconds per day, hour, minute
    localparam logic signed [23:0] SEC_DAY  = 24'sd86400;
    localparam logic signed [23:0] SEC_HOUR = 24'sd3600;
    localparam logic signed [23:0] SEC_MIN  = 24'sd60;

    // y / 100 as (y * 10486) >> 20, exact for 14-bit y
    localparam logic [13:0] DIV100_RECIP = 14'd10486;

    // 3125000 / 837 = 3733 + 479 / 837, rounded with half the divisor (418)
    localparam logic [11:0] FRAC_INT  = 12'd3733;
    localparam logic [8:0]  FRAC_REM  = 9'd479;
    localparam logic [9:0]  HALF_DEN  = 10'd418;
    // n / 837 as (n * ceil(2^41 / 837)) >> 41, exact for n below 2^31
    localparam logic [31:0] FRAC_RECIP = 32'd2627267928;

    // One whole month in the output scale
    localparam logic signed [51:0] MONTH_SCALE = 52'sd10000000000;

    // Input request and result payloads
    typedef struct packed {
        logic [13:0] year_a;
        logic [3:0]  month_a;
        logic [4:0]  day_a;
        logic [4:0]  hour_a;
        logic [5:0]  minute_a;
        logic [5:0]  second_a;
        logic [13:0] year_b;
        logic [3:0]  month_b;
        logic [4:0]  day_b;
        logic [4:0]  hour_b;
        logic [5:0]  minute_b;
        logic [5:0]  second_b;
    } item_t;

    typedef struct packed {
        logic signed [51:0] months_scaled;
        logic [1:0]         error_code;
    } result_t;

    // Stage 1: decoded dates
    typedef struct packed {
        err_t               err;
        logic               day_eq;
        logic signed [17:0] whole;
        logic signed [22:0] secdiff;
        logic [13:0]        year_a;
        logic [13:0]        year_b;
        logic [7:0]         cent_a;
        logic [7:0]         cent_b;
        logic [3:0]         month_a;
        logic [3:0]         month_b;
        logic [4:0]         day_a;
        logic [4:0]         day_b;
    } s1_t;

    // Stage 2: scaled terms
    typedef struct packed {
        err_t               err;
        logic               use_whole;
        logic               neg;
        logic [30:0]        num;
        logic [33:0]        base;
        logic signed [51:0] wscaled;
    } s2_t;

    // Stage 3: rounded fraction
    typedef struct packed {
        err_t               err;
        logic               use_whole;
        logic               neg;
        logic [20:0]        frac;
        logic [33:0]        base;
        logic signed [51:0] wscaled;
    } s3_t;

    // Days in a month
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        begin
            case (m)
                4'd2:    len = leap ? 5'd29 : 5'd28;
                4'd4:    len = 5'd30;
                4'd6:    len = 5'd30;
                4'd9:    len = 5'd30;
                4'd11:   len = 5'd30;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

@@ rtl/mbd_decode.sv @@
module mbd_decode (
    input  mbd_pkg::item_t item,
    output mbd_pkg::s1_t   s1
);
    import mbd_pkg::*;

    logic [16:0]        tot_a;
    logic [16:0]        tot_b;
    logic signed [7:0]  d_diff;
    logic signed [7:0]  h_diff;
    logic signed [7:0]  n_diff;
    logic signed [7:0]  s_diff;
    logic signed [23:0] d_ext;
    logic signed [23:0] h_ext;
    logic signed [23:0] n_ext;
    logic signed [23:0] s_ext;
    logic signed [23:0] sec_sum;
    logic [27:0]        prod_a;
    logic [27:0]        prod_b;
    logic               year_bad;
    logic               month_bad;

    // Month counts since year zero
    assign tot_a = 17'({item.year_a, 3'b000}) + 17'({item.year_a, 2'b00}) + 17'(item.month_a);
    assign tot_b = 17'({item.year_b, 3'b000}) + 17'({item.year_b, 2'b00}) + 17'(item.month_b);

    // Field differences
    assign d_diff = $signed({3'b000, item.day_a}) - $signed({3'b000, item.day_b});
    assign h_diff = $signed({3'b000, item.hour_a}) - $signed({3'b000, item.hour_b});
    assign n_diff = $signed({2'b00, item.minute_a}) - $signed({2'b00, item.minute_b});
    assign s_diff = $signed({2'b00, item.second_a}) - $signed({2'b00, item.second_b});

    assign d_ext = 24'(d_diff);
    assign h_ext = 24'(h_diff);
    assign n_ext = 24'(n_diff);
    assign s_ext = 24'(s_diff);

    assign sec_sum = d_ext * SEC_DAY + h_ext * SEC_HOUR + n_ext * SEC_MIN + s_ext;

    // Century index for the leap test
    assign prod_a = 28'(item.year_a) * 28'(DIV100_RECIP);
    assign prod_b = 28'(item.year_b) * 28'(DIV100_RECIP);

    // Range checks, year first
    assign year_bad = (item.year_a == 14'd0) || (item.year_a > YEAR_MAX) ||
                      (item.year_b == 14'd0) || (item.year_b > YEAR_MAX);
    assign month_bad = (item.month_a == 4'd0) || (item.month_a > MONTH_MAX) ||
                       (item.month_b == 4'd0) || (item.month_b > MONTH_MAX);

    always_comb
    begin
        if (year_bad)
        begin
            s1.err = ERR_YEAR;
        end
        else if (month_bad)
        begin
            s1.err = ERR_MONTH;
        end
        else
        begin
            s1.err = ERR_NONE;
        end
        s1.day_eq  = (item.day_a == item.day_b);
        s1.whole   = $signed({1'b0, tot_a} - {1'b0, tot_b});
        s1.secdiff = sec_sum[22:0];
        s1.year_a  = item.year_a;
        s1.year_b  = item.year_b;
        s1.cent_a  = prod_a[27:20];
        s1.cent_b  = prod_b[27:20];
        s1.month_a = item.month_a;
        s1.month_b = item.month_b;
        s1.day_a   = item.day_a;
        s1.day_b   = item.day_b;
    end

endmodule

@@ rtl/mbd_prep.sv @@
module mbd_prep (
    input  mbd_pkg::s1_t s1,
    output mbd_pkg::s2_t s2
);
    import mbd_pkg::*;

    logic [13:0] rem_a;
    logic [13:0] rem_b;
    logic        leap_a;
    logic        leap_b;
    logic        last_a;
    logic        last_b;
    logic        neg;
    logic [21:0] abs_s;

    // Remainder by 100 from the century index
    assign rem_a = s1.year_a - 14'(16'(s1.cent_a) * 16'd100);
    assign rem_b = s1.year_b - 14'(16'(s1.cent_b) * 16'd100);

    // Gregorian leap rule
    assign leap_a = ((s1.year_a[1:0] == 2'b00) && (rem_a != 14'd0)) ||
                    ((rem_a == 14'd0) && (s1.cent_a[1:0] == 2'b00));
    assign leap_b = ((s1.year_b[1:0] == 2'b00) && (rem_b != 14'd0)) ||
                    ((rem_b == 14'd0) && (s1.cent_b[1:0] == 2'b00));

    assign last_a = (s1.day_a == month_len(s1.month_a, leap_a));
    assign last_b = (s1.day_b == month_len(s1.month_b, leap_b));

    // Split the fraction into sign and magnitude
    assign neg   = s1.secdiff[22];
    assign abs_s = neg ? 22'(-s1.secdiff) : 22'(s1.secdiff);

    always_comb
    begin
        s2.err       = s1.err;
        s2.use_whole = s1.day_eq || (last_a && last_b);
        s2.neg       = neg;
        s2.num       = 31'(abs_s) * 31'(FRAC_REM) + 31'(HALF_DEN);
        s2.base      = 34'(abs_s) * 34'(FRAC_INT);
        s2.wscaled   = 52'(s1.whole) * MONTH_SCALE;
    end

endmodule

@@ rtl/mbd_frac.sv @@
module mbd_frac (
    input  mbd_pkg::s2_t s2,
    output mbd_pkg::s3_t s3
);
    import mbd_pkg::*;

    logic [62:0] prod;

    // Divide the rounded remainder term by 837
    assign prod = 63'(s2.num) * 63'(FRAC_RECIP);

    always_comb
    begin
        s3.err       = s2.err;
        s3.use_whole = s2.use_whole;
        s3.neg       = s2.neg;
        s3.frac      = prod[61:41];
        s3.base      = s2.base;
        s3.wscaled   = s2.wscaled;
    end

endmodule

@@ rtl/mbd_merge.sv @@
module mbd_merge (
    input  mbd_pkg::s3_t     s3,
    output mbd_pkg::result_t res
);
    import mbd_pkg::*;

    logic [34:0]        mag;
    logic signed [51:0] delta;

    // Add the integer and fractional parts, restore the sign
    assign mag = 35'(s3.base) + 35'(s3.frac);

    always_comb
    begin
        if (s3.use_whole)
        begin
            delta = '0;
        end
        else if (s3.neg)
        begin
            delta = -$signed(52'(mag));
        end
        else
        begin
            delta = $signed(52'(mag));
        end
        res.error_code = s3.err;
        if (s3.err != ERR_NONE)
        begin
            res.months_scaled = '0;
        end
        else
        begin
            res.months_scaled = s3.wscaled + delta;
        end
    end

endmodule

@@ rtl/months_between_dates_unit.sv @@
// Month distance between two date-times, B to A, scaled by 10^10.
//
// Request channel: item_valid / item_stall / item carry both dates. A
// request is taken at a rising edge with item_valid high and item_stall low.
// Result channel: result_valid / result_stall / result carry the scaled
// month count and an error code (year checked before month; zero on error).
//
// Throughput is one request per cycle while the result is not stalled:
// decode, leap and scale, reciprocal divide by 837, and the final add each
// sit in a register stage of their own.
//
// A stalled result holds in the output register. Each stage keeps its data
// while the next one is held, so item_stall rises only when all four stages
// hold data and the result is stalled. Bubbles are squeezed out.
//
// Reset clears all stage valid bits, so the block is empty and ready for
// requests once reset is released.
module months_between_dates_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  mbd_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output mbd_pkg::result_t result
);
    import mbd_pkg::*;

    logic    v1_reg;
    logic    v2_reg;
    logic    v3_reg;
    logic    v4_reg;
    logic    v1_next;
    logic    v2_next;
    logic    v3_next;
    logic    v4_next;
    logic    rdy1;
    logic    rdy2;
    logic    rdy3;
    logic    rdy4;
    s1_t     s1_next;
    s1_t     s1_reg;
    s2_t     s2_next;
    s2_t     s2_reg;
    s3_t     s3_next;
    s3_t     s3_reg;
    result_t out_next;
    result_t out_reg;

    // Stage logic
    mbd_decode u_decode (
        .item (item),
        .s1   (s1_next)
    );

    mbd_prep u_prep (
        .s1 (s1_reg),
        .s2 (s2_next)
    );

    mbd_frac u_frac (
        .s2 (s2_reg),
        .s3 (s3_next)
    );

    mbd_merge u_merge (
        .s3  (s3_reg),
        .res (out_next)
    );

    // A stage advances when empty or when the stage after it advances
    assign rdy4 = !v4_reg || !result_stall;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign v1_next = rdy1 ? item_valid : v1_reg;
    assign v2_next = rdy2 ? v1_reg : v2_reg;
    assign v3_next = rdy3 ? v2_reg : v3_reg;
    assign v4_next = rdy4 ? v3_reg : v4_reg;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // Advance payload; hold while the next stage cannot take it
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_reg <= s1_next;
        end
        if (rdy2)
        begin
            s2_reg <= s2_next;
        end
        if (rdy3)
        begin
            s3_reg <= s3_next;
        end
        if (rdy4)
        begin
            out_reg <= out_next;
        end
    end

    assign item_stall   = !rdy1;
    assign result_valid = v4_reg;
    assign result       = out_reg;

    // An error result carries a zero month count
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.error_code != ERR_NONE)) |-> (result.months_scaled == '0))
    else $error("error result with nonzero month count");

    // Requests are held off only when the pipeline is full and the result is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg && result_stall))
    else $error("request stalled with room in the pipeline");

    // Error code three is never produced
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.error_code != 2'd3))
    else $error("undefined error code on result");

    // A result taken without a stage behind it leaves the output empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !v3_reg) |=> !result_valid)
    else $error("result repeated after it was taken");

endmodule
